// ===== hdl/mmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Mahalanobis classifier package
// Shared codes, arithmetic widths and the structs that pass between the
// sequencer, the class cells and the top level.
// ----------------------------------------------------------------------------
package mmdc_pkg;

    // Default sizes of the class table.
    localparam int MAX_BANDS_DEF   = 8;
    localparam int MAX_CLASSES_DEF = 16;

    // Fixed field widths.
    localparam int SAMPLE_BITS = 16;
    localparam int LOAD_W      = 32;
    localparam int LABEL_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int ROW_W       = 3;
    localparam int IDX_W       = 4;   // holds a band index for up to 16 bands

    // Arithmetic widths, sized for the largest band count of sixteen.
    localparam int DF_W  = 34;        // sample * 2^16 - mean
    localparam int P_W   = 2 * DF_W;  // product of two multiplier operands
    localparam int A_W   = 70;        // row sum in Q24.40
    localparam int RS_W  = A_W - 24;  // row sum shifted back to Q16.16
    localparam int RS_LO = 23;        // low part of the row sum per multiply
    localparam int D_W   = 84;        // distance in Q32.32

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_MEAN  = 2'd0,
        KIND_INV   = 2'd1,
        KIND_LABEL = 2'd2,
        KIND_PIXEL = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BAND_COUNT    = 2'd0;
    localparam logic [1:0] CFG_CLASS_COUNT   = 2'd1;
    localparam logic [1:0] CFG_NODATA_ENABLE = 2'd2;
    localparam logic [1:0] CFG_NODATA_VALUE  = 2'd3;

    // Operations broadcast to the cells.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIFF,
        OP_MAC,
        OP_RLO,
        OP_RHI
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             first;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cmd;

    // Table write broadcast to the cells.
    typedef struct packed {
        logic              we_mean;
        logic              we_inv;
        logic              we_label;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [LOAD_W-1:0] value;
    } t_load;

    // Running minimum handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               have;
        logic [D_W-1:0]     best;
        logic [LABEL_W-1:0] label;
    } t_chain;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_DIFF,
        SEQ_GAP,
        SEQ_MAC,
        SEQ_BUB,
        SEQ_RLO,
        SEQ_RHI,
        SEQ_DRAIN1,
        SEQ_DRAIN2,
        SEQ_START,
        SEQ_CHAIN
    } t_seq_state;

endpackage

// ===== hdl/mmdc_if.sv =====
// ----------------------------------------------------------------------------
// Mahalanobis classifier channels
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface mmdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  class_slot;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [31:0] load_value;
    logic [15:0] sample;
    logic        last_band;

    modport source (output valid, kind, class_slot, row_index, col_index,
                    load_value, sample, last_band, input ready);
    modport sink   (input valid, kind, class_slot, row_index, col_index,
                    load_value, sample, last_band, output ready);
endinterface

interface mmdc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] class_label;
    logic        is_nodata;

    modport source (output valid, class_label, is_nodata, input ready);
    modport sink   (input valid, class_label, is_nodata, output ready);
endinterface

// ===== hdl/mmdc_seq.sv =====
// ----------------------------------------------------------------------------
// Mahalanobis classifier sequencer
// Steps all class cells in lockstep through the difference, row sum and
// distance phases of one pixel, then launches the minimum search down the
// cell chain.
// ----------------------------------------------------------------------------
module mmdc_seq #(
    parameter int MAX_BANDS = mmdc_pkg::MAX_BANDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [((MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1)-1:0] i_band_last,
    input  logic                   i_done,
    output mmdc_pkg::t_cmd         o_cmd,
    output logic                   o_chain_start,
    output logic                   o_busy
);
    import mmdc_pkg::*;

    localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    t_seq_state    r_state, n_state;
    logic [BW-1:0] r_i, n_i;
    logic [BW-1:0] r_j, n_j;

    // State and index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Next state and the command for this cycle.
    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        o_cmd.op      = OP_NONE;
        o_cmd.first   = (r_j == '0);
        o_cmd.i       = IDX_W'(r_i);
        o_cmd.j       = IDX_W'(r_j);
        o_chain_start = 1'b0;
        o_busy        = 1'b1;
        unique case (r_state)
            SEQ_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_state = SEQ_DIFF;
                    n_j     = '0;
                end
            end
            SEQ_DIFF: begin
                o_cmd.op = OP_DIFF;
                if (r_j == i_band_last) begin
                    n_state = SEQ_GAP;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            SEQ_GAP: begin
                n_state = SEQ_MAC;
                n_i     = '0;
                n_j     = '0;
            end
            SEQ_MAC: begin
                o_cmd.op = OP_MAC;
                if (r_j == i_band_last) begin
                    n_state = SEQ_BUB;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            SEQ_BUB: begin
                n_state = SEQ_RLO;
            end
            SEQ_RLO: begin
                o_cmd.op = OP_RLO;
                n_state  = SEQ_RHI;
            end
            SEQ_RHI: begin
                o_cmd.op = OP_RHI;
                if (r_i == i_band_last) begin
                    n_state = SEQ_DRAIN1;
                end else begin
                    n_state = SEQ_MAC;
                    n_i     = r_i + 1'b1;
                    n_j     = '0;
                end
            end
            SEQ_DRAIN1: begin
                n_state = SEQ_DRAIN2;
            end
            SEQ_DRAIN2: begin
                n_state = SEQ_START;
            end
            SEQ_START: begin
                o_chain_start = 1'b1;
                n_state       = SEQ_CHAIN;
            end
            SEQ_CHAIN: begin
                if (i_done) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mmdc_cell.sv =====
// ----------------------------------------------------------------------------
// Mahalanobis classifier class cell
// Holds one class slot (label, mean vector, inverse matrix), computes its
// distance with one shared multiplier and passes the running minimum on.
// ----------------------------------------------------------------------------
module mmdc_cell #(
    parameter int MAX_BANDS   = mmdc_pkg::MAX_BANDS_DEF,
    parameter int MAX_CLASSES = mmdc_pkg::MAX_CLASSES_DEF,
    parameter int IDX         = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmdc_pkg::t_load                     i_load,
    input  mmdc_pkg::t_cmd                      i_cmd,
    input  logic [mmdc_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic [$clog2(MAX_CLASSES+1)-1:0]    i_class_num,
    input  mmdc_pkg::t_chain                    i_chain,
    output mmdc_pkg::t_chain                    o_chain
);
    import mmdc_pkg::*;

    localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int IDEPTH = MAX_BANDS * MAX_BANDS;
    localparam int IW     = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

    logic [LOAD_W-1:0]  r_mean_mem [MAX_BANDS];
    logic [LOAD_W-1:0]  r_inv_mem  [IDEPTH];
    logic [LABEL_W-1:0] r_label;
    logic [LOAD_W-1:0]  r_mean_rd;
    logic [LOAD_W-1:0]  r_inv_rd;

    logic signed [DF_W-1:0] r_diff [MAX_BANDS];
    logic signed [DF_W-1:0] r_diff_rd;
    logic signed [DF_W-1:0] n_diff;
    logic signed [DF_W-1:0] w_opb;
    logic signed [P_W-1:0]  w_prod;
    logic signed [P_W-1:0]  r_prod;
    logic signed [A_W-1:0]  r_acc;
    logic signed [D_W-1:0]  r_d;
    logic [RS_W-1:0]        w_rs;

    t_cmd   r_cmd_b, r_cmd_c;
    t_chain r_chain;
    logic   r_chain_valid;

    logic          w_sel;
    logic [BW-1:0] w_wr_row;
    logic [IW-1:0] w_wr_addr;
    logic [IW-1:0] w_rd_addr;
    logic [BW-1:0] w_diff_sel;
    logic          w_active;
    logic          w_take;

    assign w_sel     = (32'(i_load.slot) == IDX);
    assign w_wr_row  = BW'(i_load.row);
    assign w_wr_addr = IW'(32'(i_load.row) * MAX_BANDS + 32'(i_load.col));
    assign w_rd_addr = IW'(32'(i_cmd.i[BW-1:0]) * MAX_BANDS + 32'(i_cmd.j[BW-1:0]));

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_load.we_mean && w_sel) begin
            r_mean_mem[w_wr_row] <= i_load.value;
        end
        r_mean_rd <= r_mean_mem[i_cmd.j[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we_inv && w_sel) begin
            r_inv_mem[w_wr_addr] <= i_load.value;
        end
        r_inv_rd <= r_inv_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we_label && w_sel) begin
            r_label <= i_load.value[LABEL_W-1:0];
        end
    end

    // Command delay line for the read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_b <= '0;
            r_cmd_c <= '0;
        end else begin
            r_cmd_b <= i_cmd;
            r_cmd_c <= r_cmd_b;
        end
    end

    // Multiplier operand for this cycle: the matching difference is read
    // by column during row sums and by row during the distance steps.
    assign w_diff_sel = (i_cmd.op == OP_MAC) ? i_cmd.j[BW-1:0] : i_cmd.i[BW-1:0];
    assign w_rs       = r_acc[A_W-1:24];
    assign n_diff     = $signed({2'b00, i_sample, 16'b0})
                      - $signed({{(DF_W-LOAD_W){r_mean_rd[LOAD_W-1]}}, r_mean_rd});

    always_comb begin
        case (r_cmd_b.op)
            OP_MAC:  w_opb = {{(DF_W-LOAD_W){r_inv_rd[LOAD_W-1]}}, r_inv_rd};
            OP_RLO:  w_opb = {{(DF_W-RS_LO){1'b0}}, w_rs[RS_LO-1:0]};
            OP_RHI:  w_opb = {{(DF_W-(RS_W-RS_LO)){w_rs[RS_W-1]}}, w_rs[RS_W-1:RS_LO]};
            default: w_opb = '0;
        endcase
    end

    assign w_prod = r_diff_rd * w_opb;

    // Difference store and the registered product.
    always_ff @(posedge i_clk) begin
        r_diff_rd <= r_diff[w_diff_sel];
        r_prod    <= w_prod;
        if (r_cmd_b.op == OP_DIFF) begin
            r_diff[r_cmd_b.j[BW-1:0]] <= n_diff;
        end
    end

    // Accumulate row sums and the distance.
    always_ff @(posedge i_clk) begin
        case (r_cmd_c.op)
            OP_DIFF: r_d <= '0;
            OP_MAC: begin
                if (r_cmd_c.first) begin
                    r_acc <= {{(A_W-P_W){r_prod[P_W-1]}}, r_prod};
                end else begin
                    r_acc <= r_acc + {{(A_W-P_W){r_prod[P_W-1]}}, r_prod};
                end
            end
            OP_RLO:  r_d <= r_d + {{(D_W-P_W){r_prod[P_W-1]}}, r_prod};
            OP_RHI:  r_d <= r_d + {r_prod[D_W-RS_LO-1:0], {RS_LO{1'b0}}};
            default: r_d <= r_d;
        endcase
    end

    // Minimum search: the first active class always wins, later ones only
    // when strictly smaller.
    assign w_active = (32'(IDX) < 32'(i_class_num));
    assign w_take   = w_active && (!i_chain.have || (r_d < $signed(i_chain.best)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_valid <= 1'b0;
        end else begin
            r_chain_valid <= i_chain.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chain.valid <= 1'b0;
        r_chain.have  <= i_chain.have | w_active;
        r_chain.best  <= w_take ? r_d : i_chain.best;
        r_chain.label <= w_take ? r_label : i_chain.label;
    end

    always_comb begin
        o_chain       = r_chain;
        o_chain.valid = r_chain_valid;
    end

endmodule

// ===== hdl/mahalanobis_min_distance_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Minimum Mahalanobis distance classifier
// Table loads, pixel band buffering, and classification by a chain of class
// cells that search for the nearest class.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on i_in. Kinds 0 to 2 load a mean, an inverse
// coefficient or a label into a class slot. Kind 3 stores one band sample;
// the word with last_band set classifies the pixel.
// One result word per classified pixel leaves on o_out.
// A pixel with N active bands (N = band_count clamped to 1..MAX_BANDS) runs
// the cell steps (one multiplier per class cell, one multiply-accumulate per
// cycle), the pipeline drain and start, and then the search down the cell
// chain; the result word is valid in the cycle after the chain finishes.
// No input word is taken during that time. A no-data pixel gives its result
// in the cycle after the last band is accepted.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
// Reset sets band_count 1, class_count 1 and no-data checking off; the class
// tables hold nothing until loaded. While the receiver stalls, the result
// word holds and loads and non-final bands are still accepted; a final band
// waits until the result word has been taken.
// ----------------------------------------------------------------------------
module mahalanobis_min_distance_classifier_unit #(
    parameter int MAX_BANDS   = mmdc_pkg::MAX_BANDS_DEF,
    parameter int MAX_CLASSES = mmdc_pkg::MAX_CLASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmdc_in_if.sink     i_in,
    mmdc_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import mmdc_pkg::*;

    localparam int BW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int NC_W = $clog2(MAX_CLASSES + 1);

    // Configuration registers.
    logic [3:0]  r_band_count;
    logic [4:0]  r_class_count;
    logic        r_nodata_en;
    logic [15:0] r_nodata_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count  <= 4'd1;
            r_class_count <= 5'd1;
            r_nodata_en   <= 1'b0;
            r_nodata_val  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BAND_COUNT:    r_band_count  <= i_cfg_data[3:0];
                CFG_CLASS_COUNT:   r_class_count <= i_cfg_data[4:0];
                CFG_NODATA_ENABLE: r_nodata_en   <= i_cfg_data[0];
                CFG_NODATA_VALUE:  r_nodata_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the counts into range.
    logic [BW-1:0]   w_band_last;
    logic [NC_W-1:0] w_class_num;

    always_comb begin
        if (r_band_count == '0) begin
            w_band_last = '0;
        end else if (32'(r_band_count) > MAX_BANDS) begin
            w_band_last = BW'(MAX_BANDS - 1);
        end else begin
            w_band_last = BW'(r_band_count - 4'd1);
        end
        if (r_class_count == '0) begin
            w_class_num = NC_W'(1);
        end else if (32'(r_class_count) > MAX_CLASSES) begin
            w_class_num = NC_W'(MAX_CLASSES);
        end else begin
            w_class_num = NC_W'(r_class_count);
        end
    end

    // Input handshake and decode.
    t_cmd   w_cmd;
    t_load  w_load;
    t_chain w_chain [MAX_CLASSES+1];
    logic   w_seq_busy;
    logic   w_chain_start;
    logic   w_acc;
    logic   w_pixel;
    logic   w_final;
    logic   w_in_range;
    logic   w_band0_nodata;
    logic   w_start;
    logic [15:0] w_band0;

    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_nodata;

    logic [SAMPLE_BITS-1:0] r_buf [MAX_BANDS];
    logic [SAMPLE_BITS-1:0] r_smp_rd;

    assign w_pixel    = (t_kind'(i_in.kind) == KIND_PIXEL);
    assign w_final    = w_pixel && i_in.last_band;
    assign i_in.ready = !w_seq_busy && !(r_out_valid && w_final);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_in_range = (32'(i_in.class_slot) < MAX_CLASSES)
                     && (32'(i_in.row_index) < MAX_BANDS);

    assign w_load.we_mean  = w_acc && w_in_range && (t_kind'(i_in.kind) == KIND_MEAN);
    assign w_load.we_inv   = w_acc && w_in_range && (t_kind'(i_in.kind) == KIND_INV)
                          && (32'(i_in.col_index) < MAX_BANDS);
    assign w_load.we_label = w_acc && w_in_range && (t_kind'(i_in.kind) == KIND_LABEL);
    assign w_load.slot     = i_in.class_slot;
    assign w_load.row      = i_in.row_index;
    assign w_load.col      = i_in.col_index;
    assign w_load.value    = i_in.load_value;

    // Band 0 as it stands after this word is stored.
    assign w_band0 = (i_in.row_index == '0) ? i_in.sample : r_buf[0];
    assign w_band0_nodata = r_nodata_en && (w_band0 == r_nodata_val);
    assign w_start = w_acc && w_final && !w_band0_nodata;

    // Pixel buffer and its registered read for the difference step.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_pixel && (32'(i_in.row_index) < MAX_BANDS)) begin
            r_buf[BW'(i_in.row_index)] <= i_in.sample;
        end
        r_smp_rd <= r_buf[w_cmd.j[BW-1:0]];
    end

    mmdc_seq #(
        .MAX_BANDS(MAX_BANDS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_band_last   (w_band_last),
        .i_done        (w_chain[MAX_CLASSES].valid),
        .o_cmd         (w_cmd),
        .o_chain_start (w_chain_start),
        .o_busy        (w_seq_busy)
    );

    // Chain of class cells.
    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].valid = w_chain_start;
    end

    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_cell
        mmdc_cell #(
            .MAX_BANDS   (MAX_BANDS),
            .MAX_CLASSES (MAX_CLASSES),
            .IDX         (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_cmd       (w_cmd),
            .i_sample    (r_smp_rd),
            .i_class_num (w_class_num),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1])
        );
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && w_final && w_band0_nodata) begin
            r_out_valid <= 1'b1;
        end else if (w_chain[MAX_CLASSES].valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_final && w_band0_nodata) begin
            r_out_label  <= '0;
            r_out_nodata <= 1'b1;
        end else if (w_chain[MAX_CLASSES].valid) begin
            r_out_label  <= w_chain[MAX_CLASSES].label;
            r_out_nodata <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.class_label = r_out_label;
    assign o_out.is_nodata   = r_out_nodata;

    // Checks.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq_busy |-> !w_acc)
        else $error("input word accepted while a pixel is being classified");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[MAX_CLASSES].valid |-> w_seq_busy)
        else $error("chain result without a pixel in flight");

    a_out_free_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[MAX_CLASSES].valid |-> !r_out_valid)
        else $error("chain result arrives while the result word is occupied");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Mahalanobis classifier testbench
// Loads random class tables, streams pixels under random idling on both
// channels and compares every result word with a built-in distance predictor.
// ----------------------------------------------------------------------------
class label_scoreboard;
    typedef struct {
        logic [15:0] label;
        logic        nodata;
    } t_result;

    t_result   pending[$];
    int        errors;
    int        checked;

    // Queue the expected result of one classified pixel.
    function void note_pixel(logic [15:0] label, logic nodata);
        t_result r;
        r.label = label;
        r.nodata = nodata;
        pending = {pending, r};
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_result(logic [15:0] label, logic nodata);
        t_result r;
        if (pending.size() == 0) begin
            $error("unexpected result word: class_label %0d is_nodata %0d", label, nodata);
            errors++;
            return;
        end
        r = pending.pop_front();
        checked++;
        if (label !== r.label) begin
            $error("class_label: expected %0d, actual %0d", r.label, label);
            errors++;
        end
        if (nodata !== r.nodata) begin
            $error("is_nodata: expected %0d, actual %0d", r.nodata, nodata);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import mmdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 8;
    localparam int NC = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    mmdc_in_if  in_ch();
    mmdc_out_if out_ch();

    mahalanobis_min_distance_classifier_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: class tables, pixel buffer and registers.
    logic signed [31:0] mean_q[NC][NB];
    logic signed [31:0] inv_q[NC][NB][NB];
    logic [15:0]        label_q[NC];
    logic [15:0]        pix_q[NB];
    logic [3:0]         bands_r;
    logic [4:0]         classes_r;
    logic               nodata_en_r;
    logic [15:0]        nodata_val_r;

    label_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  pixels_sent;
    int  loads_sent;
    longint cycles;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.class_slot = '0;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.load_value = '0;
        in_ch.sample = '0;
        in_ch.last_band = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Distance of the buffered pixel to one class, Q32.32.
    function automatic logic signed [127:0] class_distance(int c, int n);
        logic signed [63:0]  dv[NB];
        logic signed [127:0] acc;
        logic signed [127:0] total;
        logic signed [63:0]  rs;
        total = '0;
        for (int i = 0; i < n; i++)
            dv[i] = $signed({16'd0, pix_q[i], 16'd0}) - 64'(mean_q[c][i]);
        for (int i = 0; i < n; i++) begin
            acc = '0;
            for (int j = 0; j < n; j++)
                acc += 128'(inv_q[c][i][j]) * 128'(dv[j]);
            rs = 64'(acc >>> 24);
            total += 128'(dv[i]) * 128'(rs);
        end
        return total;
    endfunction

    // Update the predictor with one accepted word.
    function automatic void predict_word(t_kind kind, int slot, int row, int col,
                                         logic [31:0] value, logic [15:0] smp,
                                         logic last);
        int n;
        int k;
        logic signed [127:0] best;
        logic signed [127:0] d;
        logic [15:0] lab;
        case (kind)
            KIND_MEAN:  mean_q[slot][row] = value;
            KIND_INV:   inv_q[slot][row][col] = value;
            KIND_LABEL: label_q[slot] = value[15:0];
            default: begin
                pix_q[row] = smp;
                if (last) begin
                    if (nodata_en_r && pix_q[0] == nodata_val_r) begin
                        sb.note_pixel(16'd0, 1'b1);
                    end else begin
                        n = (bands_r == 0) ? 1 : (bands_r > NB ? NB : bands_r);
                        k = (classes_r == 0) ? 1 : (classes_r > NC ? NC : classes_r);
                        best = class_distance(0, n);
                        lab = label_q[0];
                        for (int c = 1; c < k; c++) begin
                            d = class_distance(c, n);
                            if (d < best) begin
                                best = d;
                                lab = label_q[c];
                            end
                        end
                        sb.note_pixel(lab, 1'b0);
                    end
                end
            end
        endcase
    endfunction

    // Send one word and wait for its handshake. Valid stays high after the
    // handshake until the next word, an idle cycle or a drain takes it down.
    task automatic send_word(t_kind kind, int slot, int row, int col,
                             logic [31:0] value, logic [15:0] smp, logic last);
        i_cfg_we <= 1'b0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.class_slot <= slot[3:0];
        in_ch.row_index <= row[2:0];
        in_ch.col_index <= col[2:0];
        in_ch.load_value <= value;
        in_ch.sample <= smp;
        in_ch.last_band <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_word(kind, slot, row, col, value, smp, last);
        if (kind == KIND_PIXEL) pixels_sent++;
        else loads_sent++;
    endtask

    // Write one register while the block is idle; the next word or drain
    // drops the write enable.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_BAND_COUNT:    bands_r = value[3:0];
            CFG_CLASS_COUNT:   classes_r = value[4:0];
            CFG_NODATA_ENABLE: nodata_en_r = value[0];
            default:           nodata_val_r = value;
        endcase
    endtask

    // Wait until every expected result has arrived, then let the block settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_mean();
        // Mostly near the sample range, sometimes anything at all.
        if ($urandom_range(9) == 0) return $urandom;
        return {16'($urandom_range(65535)), 16'(0)} + 32'($urandom_range(65535));
    endfunction

    function automatic logic [31:0] rand_coef(bit diag);
        case ($urandom_range(5))
            0: return $urandom;
            1: return diag ? 32'h7fffffff : 32'h80000000;
            default: return diag ? 32'($urandom_range(1 << 24)) :
                             32'($signed(32'($urandom_range(1 << 21))) - (1 << 20));
        endcase
    endfunction

    // Fill every slot: label, mean and full inverse matrix.
    task automatic load_all_classes();
        for (int c = 0; c < NC; c++) begin
            send_word(KIND_LABEL, c, 0, 0, $urandom, 16'd0, 1'b0);
            for (int r = 0; r < NB; r++) begin
                send_word(KIND_MEAN, c, r, 0, rand_mean(), 16'd0, 1'b0);
                for (int q = 0; q < NB; q++)
                    send_word(KIND_INV, c, r, q, rand_coef(r == q), 16'd0, 1'b0);
            end
        end
    endtask

    // One pixel: all bands in use, in random order, the last one flagged.
    task automatic send_pixel(bit use_nodata);
        int order[NB];
        int t;
        int s;
        for (int b = 0; b < NB; b++) order[b] = b;
        for (int b = NB - 1; b > 0; b--) begin
            s = $urandom_range(b);
            t = order[b]; order[b] = order[s]; order[s] = t;
        end
        for (int b = 0; b < NB; b++) begin
            if (use_nodata && order[b] == 0)
                send_word(KIND_PIXEL, $urandom_range(15), 0, $urandom_range(7),
                          $urandom, nodata_val_r, b == NB - 1);
            else
                send_word(KIND_PIXEL, $urandom_range(15), order[b], $urandom_range(7),
                          $urandom, ($urandom_range(3) == 0) ?
                          16'($urandom_range(1) ? 16'hffff : 16'h0) :
                          16'($urandom_range(65535)), b == NB - 1);
        end
    endtask

    // Receiver: random stalls, every accepted word checked.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.class_label, out_ch.is_nodata);
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        bands_r = 4'd1;
        classes_r = 5'd1;
        nodata_en_r = 1'b0;
        nodata_val_r = 16'd0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full tables at reset settings, then the extremes.
        load_all_classes();
        send_word(KIND_PIXEL, 0, 0, 0, 32'h0, 16'h0000, 1'b1);
        send_word(KIND_PIXEL, 0, 0, 0, 32'h0, 16'hffff, 1'b1);
        drain_results();
        write_reg(CFG_BAND_COUNT, 16'd8);
        write_reg(CFG_CLASS_COUNT, 16'd16);
        write_reg(CFG_NODATA_VALUE, 16'hffff);
        write_reg(CFG_NODATA_ENABLE, 16'd1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        // Equal classes: the first one must win a tie.
        send_word(KIND_LABEL, 1, 0, 0, 32'hffff_abcd, 16'd0, 1'b0);
        for (int r = 0; r < NB; r++) begin
            send_word(KIND_MEAN, 1, r, 0, mean_q[0][r], 16'd0, 1'b0);
            for (int q = 0; q < NB; q++)
                send_word(KIND_INV, 1, r, q, inv_q[0][r][q], 16'd0, 1'b0);
        end
        send_pixel(1'b0);
        drain_results();
        write_reg(CFG_NODATA_VALUE, 16'h0000);
        send_pixel(1'b1);
        drain_results();

        // Random phases with varied settings and idling.
        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 26 : (ph < 8 ? 83 : 0);
            recv_idle_pct = (ph < 4) ? 83 : (ph < 8 ? 26 : 0);
            write_reg(CFG_BAND_COUNT, (ph % 3 == 0) ? 16'd1 :
                      (ph % 3 == 1) ? 16'd8 : 16'($urandom_range(15)));
            write_reg(CFG_CLASS_COUNT, (ph % 4 == 0) ? 16'd16 :
                      (ph % 4 == 1) ? 16'd1 : 16'($urandom_range(31)));
            write_reg(CFG_NODATA_ENABLE, 16'($urandom_range(1)));
            write_reg(CFG_NODATA_VALUE, 16'($urandom_range(65535)));
            for (int k = 0; k < 2; k++) begin
                if ($urandom_range(3) == 0) begin
                    // Rewrite a few table entries between pixels.
                    send_word(KIND_MEAN, $urandom_range(15), $urandom_range(7), 0,
                              rand_mean(), 16'd0, 1'b0);
                    send_word(KIND_INV, $urandom_range(15), $urandom_range(7),
                              $urandom_range(7), rand_coef($urandom_range(1)), 16'd0, 1'b0);
                    send_word(KIND_LABEL, $urandom_range(15), $urandom_range(7), 0,
                              $urandom, 16'd0, 1'b0);
                end
                send_pixel($urandom_range(4) == 0);
            end
            if (ph == 5) drain_results();
            drain_results();
        end

        drain_results();
        $display("Covered %0d pixel words and %0d table loads; %0d results checked.",
                 pixels_sent, loads_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
